### rtl/mpfb_pkg.sv
// Shared constants, types and helpers of the monochrome page frame buffer.
package mpfb_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_PAGES   = 8;
  localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
  localparam int STORE_BYTES    = SCREEN_PAGES * SCREEN_COLUMNS;
  localparam int ADDR_W         = $clog2(STORE_BYTES);
  localparam int PAGE_W         = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int HEADER_BYTES   = 3;
  localparam int POS_W          = $clog2(SCREEN_COLUMNS + HEADER_BYTES);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_LINK = 1'b1;

  typedef enum logic [2:0] {
    REQ_DRAW    = 3'd0,
    REQ_READ    = 3'd1,
    REQ_FILL    = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_REFRESH = 3'd4,
    REQ_TICK    = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAW,
    S_READ,
    S_TICK,
    S_FILL_RD,
    S_FILL_WR
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic       pixel;
    logic [7:0] data_byte;
    logic       is_data;
    logic       frame_end;
  } res_t;

  // store address of a column byte in a storage page
  function automatic logic [ADDR_W-1:0] page_addr(logic [7:0] col, logic [PAGE_W-1:0] page);
    return ADDR_W'(int'(page) * SCREEN_COLUMNS + int'(col));
  endfunction

  // row block 0 is the top eight rows, kept in the last page
  function automatic logic [ADDR_W-1:0] blk_addr(logic [7:0] col, logic [PAGE_W-1:0] blk);
    logic [PAGE_W-1:0] page;
    page = PAGE_W'(SCREEN_PAGES - 1) - blk;
    return page_addr(col, page);
  endfunction

  // bits for rows lo..hi of one block, row 0 at bit 7
  function automatic logic [7:0] row_mask(logic [2:0] lo, logic [2:0] hi);
    return (8'hff >> lo) & (8'hff << (3'd7 - hi));
  endfunction

  function automatic logic [7:0] merge_byte(logic [7:0] old, logic [7:0] mask, logic on);
    return on ? (old | mask) : (old & ~mask);
  endfunction

endpackage

### rtl/mono_page_frame_buffer.sv
// Top level of the monochrome page frame buffer with result output register.
//
// A request transfers at a rising edge with start high and busy low. After reset
// and after a clear-all request the store is swept one byte a cycle and busy stays
// high until it ends. Draw pixel reads and writes back one store byte; read pixel
// reads the store byte on screen and answers at once off screen; a refresh tick
// sends a command byte at once and a data byte after reading it from the store;
// start refresh and ignored requests stay idle. A fill reads and writes back each
// touched column byte (columns times 8-row blocks covered). The store has one read
// and one write port; draw and fill read a byte and then write it back, the sweep
// only writes. A result appears on the output ports in the cycle after it is
// produced, held for one cycle with result_valid high; it cannot be stalled.
module mono_page_frame_buffer
  import mpfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type,
  input  logic [7:0] col_a,
  input  logic [7:0] row_a,
  input  logic [7:0] col_b,
  input  logic [7:0] row_b,
  input  logic       pixel_on,
  output logic       result_valid,
  output logic       result_kind,
  output logic       pixel_value,
  output logic [7:0] link_byte,
  output logic       is_data,
  output logic       frame_end
);

  mem_req_t   mreq;
  logic [7:0] rd_data;
  res_t       res;
  res_t       res_q;

  mpfb_store u_store (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  mpfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .col_a    (col_a),
    .row_a    (row_a),
    .col_b    (col_b),
    .row_b    (row_b),
    .pixel_on (pixel_on),
    .rd_data  (rd_data),
    .mreq     (mreq),
    .res      (res),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_q.valid <= 1'b0;
    end else begin
      res_q.valid <= res.valid;
    end
    res_q.kind      <= res.kind;
    res_q.pixel     <= res.pixel;
    res_q.data_byte <= res.data_byte;
    res_q.is_data   <= res.is_data;
    res_q.frame_end <= res.frame_end;
  end

  assign result_valid = res_q.valid;
  assign result_kind  = res_q.kind;
  assign pixel_value  = res_q.pixel;
  assign link_byte    = res_q.data_byte;
  assign is_data      = res_q.is_data;
  assign frame_end    = res_q.frame_end;

  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("store sweep not started after reset");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_CLEAR |=> busy)
    else $error("clear-all transfer did not start a sweep");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> is_data && result_kind == KIND_LINK)
    else $error("frame end on a byte that is not link data");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_READ |-> link_byte == 8'h00 && !is_data && !frame_end)
    else $error("read answer carries link fields");

endmodule

### rtl/mpfb_store.sv
// Pixel byte memory: one write port, one read port with registered data.
module mpfb_store
  import mpfb_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   mreq,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    rd_data <= mem[mreq.raddr];
  end

endmodule

### rtl/mpfb_ctrl.sv
// Request sequencer: read-modify-write of store bytes, fill walk, clear sweep, refresh.
module mpfb_ctrl
  import mpfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] req_type,
  input  logic [7:0] col_a,
  input  logic [7:0] row_a,
  input  logic [7:0] col_b,
  input  logic [7:0] row_b,
  input  logic       pixel_on,
  input  logic [7:0] rd_data,
  output mem_req_t   mreq,
  output res_t       res,
  output logic       busy
);

  state_t st, st_next;

  logic              ref_active;
  logic [PAGE_W-1:0] ref_page;
  logic [POS_W-1:0]  ref_pos;
  logic [ADDR_W-1:0] clr_addr;

  logic [ADDR_W-1:0] op_addr;
  logic [7:0]        op_mask;
  logic              op_on;
  logic              op_end;
  logic [7:0]        fc, fc_end;
  logic [PAGE_W-1:0] fb, fb_first, fb_end;
  logic [2:0]        r_lo, r_hi;

  logic              a_on;
  logic [ADDR_W-1:0] a_addr;
  logic [7:0]        a_mask;
  logic [7:0]        col_b_clip, row_b_clip;
  logic              fill_ok;
  logic              ref_cmd;
  logic [7:0]        ref_col;
  logic              ref_last_col, ref_last_page;
  logic [7:0]        cmd_byte;
  logic [7:0]        fmask;
  logic              clr_last, fill_last;

  assign a_on   = ({1'b0, col_a} < 9'(SCREEN_COLUMNS)) && ({1'b0, row_a} < 9'(SCREEN_ROWS));
  assign a_addr = blk_addr(col_a, row_a[PAGE_W+2:3]);
  assign a_mask = row_mask(row_a[2:0], row_a[2:0]);

  assign col_b_clip = ({1'b0, col_b} >= 9'(SCREEN_COLUMNS)) ? 8'(SCREEN_COLUMNS - 1) : col_b;
  assign row_b_clip = ({1'b0, row_b} >= 9'(SCREEN_ROWS)) ? 8'(SCREEN_ROWS - 1) : row_b;
  assign fill_ok    = (col_a <= col_b_clip) && (row_a <= row_b_clip);

  assign ref_cmd       = ref_pos < POS_W'(HEADER_BYTES);
  assign ref_col       = 8'(ref_pos - POS_W'(HEADER_BYTES));
  assign ref_last_col  = ref_col == 8'(SCREEN_COLUMNS - 1);
  assign ref_last_page = ref_page == PAGE_W'(SCREEN_PAGES - 1);

  always_comb begin
    priority if (ref_pos == POS_W'(0)) begin
      cmd_byte = CMD_PAGE_BASE + 8'(ref_page);
    end else if (ref_pos == POS_W'(1)) begin
      cmd_byte = CMD_COL_LOW;
    end else begin
      cmd_byte = CMD_COL_HIGH;
    end
  end

  // partial rows only in the first and last block of the rectangle
  assign fmask = row_mask((fb == fb_first) ? r_lo : 3'd0, (fb == fb_end) ? r_hi : 3'd7);

  assign clr_last  = clr_addr == ADDR_W'(STORE_BYTES - 1);
  assign fill_last = (fb == fb_end) && (fc == fc_end);
  assign busy      = st != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    mreq    = '0;
    res     = '0;
    unique case (st)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_addr;
        mreq.wdata = 8'h00;
        if (clr_last) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_DRAW: begin
              if (a_on) begin
                mreq.raddr = a_addr;
                st_next    = S_DRAW;
              end
            end
            REQ_READ: begin
              if (a_on) begin
                mreq.raddr = a_addr;
                st_next    = S_READ;
              end else begin
                res.valid = 1'b1;
                res.kind  = KIND_READ;
              end
            end
            REQ_FILL: begin
              if (fill_ok) begin
                st_next = S_FILL_RD;
              end
            end
            REQ_CLEAR: begin
              st_next = S_CLEAR;
            end
            REQ_REFRESH: begin
            end
            REQ_TICK: begin
              if (ref_active) begin
                if (ref_cmd) begin
                  res.valid     = 1'b1;
                  res.kind      = KIND_LINK;
                  res.data_byte = cmd_byte;
                end else begin
                  mreq.raddr = page_addr(ref_col, ref_page);
                  st_next    = S_TICK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAW: begin
        mreq.we    = 1'b1;
        mreq.waddr = op_addr;
        mreq.wdata = merge_byte(rd_data, op_mask, op_on);
        st_next    = S_IDLE;
      end
      S_READ: begin
        res.valid = 1'b1;
        res.kind  = KIND_READ;
        res.pixel = |(rd_data & op_mask);
        st_next   = S_IDLE;
      end
      S_TICK: begin
        res.valid     = 1'b1;
        res.kind      = KIND_LINK;
        res.data_byte = rd_data;
        res.is_data   = 1'b1;
        res.frame_end = op_end;
        st_next       = S_IDLE;
      end
      S_FILL_RD: begin
        mreq.raddr = blk_addr(fc, fb);
        st_next    = S_FILL_WR;
      end
      S_FILL_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = blk_addr(fc, fb);
        mreq.wdata = merge_byte(rd_data, fmask, op_on);
        st_next    = fill_last ? S_IDLE : S_FILL_RD;
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_active <= 1'b0;
      ref_page   <= '0;
      ref_pos    <= '0;
      clr_addr   <= '0;
    end else begin
      unique case (st)
        S_CLEAR: begin
          clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            unique case (req_type)
              REQ_DRAW, REQ_READ: begin
                op_addr <= a_addr;
                op_mask <= a_mask;
                op_on   <= pixel_on;
              end
              REQ_FILL: begin
                fc       <= col_a;
                fc_end   <= col_b_clip;
                fb       <= row_a[PAGE_W+2:3];
                fb_first <= row_a[PAGE_W+2:3];
                fb_end   <= row_b_clip[PAGE_W+2:3];
                r_lo     <= row_a[2:0];
                r_hi     <= row_b_clip[2:0];
                op_on    <= pixel_on;
              end
              REQ_CLEAR: begin
                clr_addr <= '0;
              end
              REQ_REFRESH: begin
                ref_active <= 1'b1;
                ref_page   <= '0;
                ref_pos    <= '0;
              end
              REQ_TICK: begin
                if (ref_active) begin
                  if (ref_cmd) begin
                    ref_pos <= ref_pos + 1'b1;
                  end else begin
                    op_end <= ref_last_col && ref_last_page;
                    if (ref_last_col) begin
                      ref_pos <= '0;
                      if (ref_last_page) begin
                        ref_active <= 1'b0;
                        ref_page   <= '0;
                      end else begin
                        ref_page <= ref_page + 1'b1;
                      end
                    end else begin
                      ref_pos <= ref_pos + 1'b1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FILL_WR: begin
          // walk all blocks of a column, then step to the next column
          if (fb == fb_end) begin
            fb <= fb_first;
            fc <= fc + 1'b1;
          end else begin
            fb <= fb + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
